### rtl/core/ohp_pkg.sv
// shared types and constants for the obex header stream parser
// no dependencies; compiled first
`default_nettype none

package ohp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;

    // header id type field is the top two bits of the id
    localparam logic [1:0] HI_TYPE_VAR_LO = 2'd1;
    localparam logic [1:0] HI_TYPE_ONE    = 2'd2;

    // length overhead and fixed content sizes
    localparam logic [LEN_W-1:0] LEN_OVERHEAD = 16'd3;
    localparam logic [LEN_W-1:0] LEN_FIELD    = 16'd2;
    localparam logic [LEN_W-1:0] CONTENT_ONE  = 16'd1;
    localparam logic [LEN_W-1:0] CONTENT_FOUR = 16'd4;

    typedef enum logic [1:0] {
        KIND_ID      = 2'd0,
        KIND_LENGTH  = 2'd1,
        KIND_CONTENT = 2'd2,
        KIND_IGNORED = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              block_first;
        logic [LEN_W-1:0]  total_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] header_id;
        t_kind             byte_kind;
        logic [BYTE_W-1:0] content_byte;
        logic [LEN_W-1:0]  content_length;
        logic              header_start;
        logic              header_end;
        logic              parse_error;
        logic              block_done;
        logic              block_ok;
    } t_res_item;

endpackage

`default_nettype wire

### rtl/core/ohp_if.sv
// valid/ready channel interfaces for header bytes in and tagged results out
// depends on ohp_pkg
`default_nettype none

interface ohp_in_if import ohp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              block_first;
    logic [LEN_W-1:0]  total_length;

    modport source (output valid, output data_byte, output block_first,
                    output total_length, input ready);
    modport sink   (input valid, input data_byte, input block_first,
                    input total_length, output ready);
endinterface

interface ohp_out_if import ohp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] header_id;
    t_kind             byte_kind;
    logic [BYTE_W-1:0] content_byte;
    logic [LEN_W-1:0]  content_length;
    logic              header_start;
    logic              header_end;
    logic              parse_error;
    logic              block_done;
    logic              block_ok;

    modport source (output valid, output header_id, output byte_kind,
                    output content_byte, output content_length,
                    output header_start, output header_end, output parse_error,
                    output block_done, output block_ok, input ready);
    modport sink   (input valid, input header_id, input byte_kind,
                    input content_byte, input content_length,
                    input header_start, input header_end, input parse_error,
                    input block_done, input block_ok, output ready);
endinterface

`default_nettype wire

### rtl/core/ohp_in_stage.sv
// input register: captures one header byte transaction
// depends on ohp_pkg and ohp_in_if
`default_nettype none

module ohp_in_stage import ohp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ohp_in_if.sink        i_hdr,
    input  wire logic     i_adv,
    output logic          o_vld,
    output t_in_item      o_item
);

    logic     r_vld;
    t_in_item r_item;
    logic     w_load;

    // free slot, or the held byte moves on this cycle
    assign i_hdr.ready = !r_vld || i_adv;
    assign w_load      = i_hdr.valid && i_hdr.ready;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_load) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.data_byte    <= i_hdr.data_byte;
            r_item.block_first  <= i_hdr.block_first;
            r_item.total_length <= i_hdr.total_length;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

`default_nettype wire

### rtl/core/ohp_parse_core.sv
// header split state machine: tags one byte per step and tracks block state
// depends on ohp_pkg
`default_nettype none

module ohp_parse_core import ohp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output t_res_item     o_res
);

    typedef enum logic [2:0] {
        PH_ID      = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_CONTENT = 3'd3,
        PH_IGNORE  = 3'd4
    } t_phase;

    t_phase             r_phase,   n_phase;
    logic [LEN_W-1:0]   r_left,    n_left;
    logic [LEN_W-1:0]   r_cleft,   n_cleft;
    logic [BYTE_W-1:0]  r_id,      n_id;
    logic [BYTE_W-1:0]  r_len_hi,  n_len_hi;
    logic               r_err,     n_err;
    logic [LEN_W-1:0]   r_hcont,   n_hcont;

    // values after a block start has been applied
    t_phase             w_phase;
    logic [LEN_W-1:0]   w_left;
    logic [LEN_W-1:0]   w_cleft;
    logic [LEN_W-1:0]   w_hcont;
    logic               w_err_seen;
    logic [LEN_W-1:0]   w_remain;
    logic [LEN_W-1:0]   w_len;
    logic [LEN_W-1:0]   w_vlen;
    logic [LEN_W-1:0]   w_fixed;
    logic [LEN_W-1:0]   w_cdec;
    logic [1:0]         w_type;
    logic               w_bad;

    assign w_phase    = i_item.block_first ? PH_ID : r_phase;
    assign w_left     = i_item.block_first ? i_item.total_length : r_left;
    assign w_cleft    = i_item.block_first ? '0 : r_cleft;
    assign w_hcont    = i_item.block_first ? '0 : r_hcont;
    assign w_err_seen = i_item.block_first ? 1'b0 : r_err;

    assign w_remain = w_left - LEN_W'(1);
    assign w_type   = i_item.data_byte[BYTE_W-1 -: 2];
    assign w_fixed  = (w_type == HI_TYPE_ONE) ? CONTENT_ONE : CONTENT_FOUR;
    assign w_len    = {r_len_hi, i_item.data_byte};
    assign w_vlen   = w_len - LEN_OVERHEAD;
    assign w_cdec   = (w_cleft != '0) ? (w_cleft - LEN_W'(1)) : w_cleft;

    // per-byte tagging and next state
    always_comb begin
        n_phase  = w_phase;
        n_left   = w_left;
        n_cleft  = w_cleft;
        n_hcont  = w_hcont;
        n_err    = w_err_seen;
        n_id     = r_id;
        n_len_hi = r_len_hi;
        w_bad    = 1'b0;

        o_res.header_id      = r_id;
        o_res.byte_kind      = KIND_IGNORED;
        o_res.content_byte   = i_item.data_byte;
        o_res.content_length = '0;
        o_res.header_start   = 1'b0;
        o_res.header_end     = 1'b0;
        o_res.parse_error    = 1'b0;
        o_res.block_done     = 1'b0;
        o_res.block_ok       = 1'b0;

        if (w_left != '0) begin
            n_left = w_remain;

            unique case (w_phase)
                PH_ID: begin
                    n_id                = i_item.data_byte;
                    o_res.byte_kind     = KIND_ID;
                    o_res.header_start  = 1'b1;
                    if (w_type <= HI_TYPE_VAR_LO) begin
                        if (w_remain < LEN_FIELD) begin
                            w_bad = 1'b1;
                        end else begin
                            n_hcont = '0;
                            n_phase = PH_LEN_HI;
                        end
                    end else if (w_fixed > w_remain) begin
                        w_bad = 1'b1;
                    end else begin
                        n_hcont              = w_fixed;
                        n_cleft              = w_fixed;
                        o_res.content_length = w_fixed;
                        n_phase              = PH_CONTENT;
                    end
                end
                PH_LEN_HI: begin
                    o_res.byte_kind = KIND_LENGTH;
                    n_len_hi        = i_item.data_byte;
                    n_phase         = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    o_res.byte_kind = KIND_LENGTH;
                    if (w_len < LEN_OVERHEAD || w_vlen > w_remain) begin
                        w_bad = 1'b1;
                    end else begin
                        n_hcont              = w_vlen;
                        n_cleft              = w_vlen;
                        o_res.content_length = w_vlen;
                        if (w_vlen == '0) begin
                            o_res.header_end = 1'b1;
                            n_phase          = PH_ID;
                        end else begin
                            n_phase = PH_CONTENT;
                        end
                    end
                end
                PH_CONTENT: begin
                    o_res.byte_kind      = KIND_CONTENT;
                    o_res.content_length = w_hcont;
                    n_cleft              = w_cdec;
                    if (w_cdec == '0) begin
                        o_res.header_end = 1'b1;
                        n_phase          = PH_ID;
                    end
                end
                default: begin
                    o_res.byte_kind = KIND_IGNORED;
                end
            endcase

            // error stops parsing for the rest of the block
            if (w_bad) begin
                n_err                = 1'b1;
                n_phase              = PH_IGNORE;
                o_res.content_length = '0;
                o_res.header_end     = 1'b0;
                o_res.parse_error    = 1'b1;
            end

            // last byte of the block
            if (w_remain == '0) begin
                o_res.block_done = 1'b1;
                o_res.block_ok   = !n_err;
                n_phase          = PH_ID;
                n_cleft          = '0;
            end

            o_res.header_id = n_id;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ID;
            r_left   <= '0;
            r_cleft  <= '0;
            r_id     <= '0;
            r_len_hi <= '0;
            r_err    <= 1'b0;
            r_hcont  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_cleft  <= n_cleft;
            r_id     <= n_id;
            r_len_hi <= n_len_hi;
            r_err    <= n_err;
            r_hcont  <= n_hcont;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ohp_out_stage.sv
// result register: holds one tagged byte until the sink takes it
// depends on ohp_pkg and ohp_out_if
`default_nettype none

module ohp_out_stage import ohp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_res_item i_res,
    output logic           o_ready,
    ohp_out_if.source      o_res
);

    logic      r_vld;
    t_res_item r_res;

    // room when empty or when the held result leaves this cycle
    assign o_ready = !r_vld || o_res.ready;

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid          = r_vld;
    assign o_res.header_id      = r_res.header_id;
    assign o_res.byte_kind      = r_res.byte_kind;
    assign o_res.content_byte   = r_res.content_byte;
    assign o_res.content_length = r_res.content_length;
    assign o_res.header_start   = r_res.header_start;
    assign o_res.header_end     = r_res.header_end;
    assign o_res.parse_error    = r_res.parse_error;
    assign o_res.block_done     = r_res.block_done;
    assign o_res.block_ok       = r_res.block_ok;

endmodule

`default_nettype wire

### rtl/core/obex_header_stream_parser.sv
// top level of the obex header stream parser
// depends on ohp_pkg, ohp_if, ohp_in_stage, ohp_parse_core, ohp_out_stage
//
//  port    dir  handshake     payload
//  i_hdr   in   valid/ready   data_byte, block_first, total_length
//  o_res   out  valid/ready   header_id, byte_kind, content_byte, content_length,
//                             header_start, header_end, parse_error,
//                             block_done, block_ok
//
// one result per byte, one byte per cycle sustained while the sink stays ready
// each byte passes the input register, then the parser state and result register
// the parser state advances only when a byte moves into the result register
// synchronous active-low reset puts the parser in the expect-id phase, no block open
// a stalled sink holds the result register; the input register still takes one byte
`default_nettype none

module obex_header_stream_parser import ohp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ohp_in_if.sink    i_hdr,
    ohp_out_if.source o_res
);

    logic      w_in_vld;
    t_in_item  w_in_item;
    logic      w_out_rdy;
    logic      w_adv;
    t_res_item w_res;

    // a transaction advances when the input register holds one and the result slot is free
    assign w_adv = w_in_vld && w_out_rdy;

    ohp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (i_hdr),
        .i_adv   (w_adv),
        .o_vld   (w_in_vld),
        .o_item  (w_in_item)
    );

    ohp_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_item  (w_in_item),
        .o_res   (w_res)
    );

    ohp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_adv),
        .i_res   (w_res),
        .o_ready (w_out_rdy),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

### dv/obex_header_stream_parser_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for obex_header_stream_parser: header blocks in, tagged bytes out
// depends on ohp_pkg, ohp_if and the rtl top; a byte-level parser model predicts every result

module obex_header_stream_parser_tb;
    import ohp_pkg::*;

    // header type with the high length form, the other one comes from the package
    localparam logic [1:0] HT_VAR_HI = 2'd0;

    localparam int unsigned RANDOM_BYTES = 1200;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned HOLD_AFTER   = 400;
    localparam int unsigned TAIL_CYCLES  = 10;

    typedef enum logic [2:0] {
        P_EXPECT_ID,
        P_LEN_HI,
        P_LEN_LO,
        P_CONTENT,
        P_IGNORE
    } t_parse_phase;

    // parser model and queue of predicted tagged bytes
    class ohp_byte_scoreboard;
        t_parse_phase      phase;
        logic [LEN_W-1:0]  block_left;
        logic [LEN_W-1:0]  content_left;
        logic [LEN_W-1:0]  header_len;
        logic [BYTE_W-1:0] cur_id;
        logic [BYTE_W-1:0] len_hi;
        bit                err_seen;
        t_res_item         tagged_q[$];
        int unsigned       inputs_seen;
        int unsigned       mismatches;

        function new();
            phase        = P_EXPECT_ID;
            block_left   = '0;
            content_left = '0;
            header_len   = '0;
            cur_id       = '0;
            len_hi       = '0;
            err_seen     = 1'b0;
            inputs_seen  = 0;
            mismatches   = 0;
        endfunction

        function int unsigned pending();
            return tagged_q.size();
        endfunction

        function string fmt_res(t_res_item r);
            return {$sformatf("id=%02h kind=%0d byte=%02h clen=%0d ",
                              r.header_id, r.byte_kind, r.content_byte, r.content_length),
                    $sformatf("st=%b end=%b err=%b done=%b ok=%b",
                              r.header_start, r.header_end, r.parse_error, r.block_done,
                              r.block_ok)};
        endfunction

        // advance the parser by one accepted byte and queue the tagged result
        function void note_input(t_in_item it);
            t_res_item         r;
            logic [LEN_W-1:0]  remaining;
            logic [LEN_W-1:0]  full_len;
            logic [LEN_W-1:0]  n;
            logic [1:0]        htype;
            bit                bad;
            inputs_seen++;
            r              = '0;
            r.byte_kind    = KIND_IGNORED;
            r.content_byte = it.data_byte;
            bad            = 1'b0;

            // a new block restarts parsing, dropping any open one
            if (it.block_first) begin
                block_left   = it.total_length;
                err_seen     = 1'b0;
                phase        = P_EXPECT_ID;
                content_left = '0;
                header_len   = '0;
            end

            if (block_left != 0) begin
                block_left = block_left - 1'b1;
                remaining  = block_left;
                case (phase)
                    P_EXPECT_ID: begin
                        htype          = it.data_byte[7:6];
                        cur_id         = it.data_byte;
                        r.byte_kind    = KIND_ID;
                        r.header_start = 1'b1;
                        if (htype <= HI_TYPE_VAR_LO) begin
                            if (remaining < LEN_FIELD) begin
                                bad = 1'b1;
                            end else begin
                                header_len = '0;
                                phase      = P_LEN_HI;
                            end
                        end else begin
                            n = (htype == HI_TYPE_ONE) ? CONTENT_ONE : CONTENT_FOUR;
                            if (n > remaining) begin
                                bad = 1'b1;
                            end else begin
                                header_len       = n;
                                content_left     = n;
                                r.content_length = n;
                                phase            = P_CONTENT;
                            end
                        end
                    end
                    P_LEN_HI: begin
                        r.byte_kind = KIND_LENGTH;
                        len_hi      = it.data_byte;
                        phase       = P_LEN_LO;
                    end
                    P_LEN_LO: begin
                        full_len    = {len_hi, it.data_byte};
                        r.byte_kind = KIND_LENGTH;
                        if (full_len < LEN_OVERHEAD) begin
                            bad = 1'b1;
                        end else begin
                            n = full_len - LEN_OVERHEAD;
                            if (n > remaining) begin
                                bad = 1'b1;
                            end else begin
                                header_len       = n;
                                content_left     = n;
                                r.content_length = n;
                                if (n == 0) begin
                                    r.header_end = 1'b1;
                                    phase        = P_EXPECT_ID;
                                end else begin
                                    phase = P_CONTENT;
                                end
                            end
                        end
                    end
                    P_CONTENT: begin
                        r.byte_kind      = KIND_CONTENT;
                        r.content_length = header_len;
                        if (content_left > 0)
                            content_left = content_left - 1'b1;
                        if (content_left == 0) begin
                            r.header_end = 1'b1;
                            phase        = P_EXPECT_ID;
                        end
                    end
                    default: begin
                        r.byte_kind = KIND_IGNORED;
                    end
                endcase

                // an error silences the rest of the block
                if (bad) begin
                    err_seen         = 1'b1;
                    phase            = P_IGNORE;
                    r.content_length = '0;
                    r.header_end     = 1'b0;
                    r.parse_error    = 1'b1;
                end

                if (remaining == 0) begin
                    r.block_done = 1'b1;
                    r.block_ok   = !err_seen;
                    phase        = P_EXPECT_ID;
                    content_left = '0;
                end
            end
            r.header_id = cur_id;
            tagged_q.push_back(r);
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(t_res_item got);
            t_res_item want;
            if (tagged_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result %s", $realtime, fmt_res(got));
            end else begin
                want = tagged_q.pop_front();
                if (got.header_id !== want.header_id || got.byte_kind !== want.byte_kind ||
                    got.content_byte !== want.content_byte ||
                    got.content_length !== want.content_length ||
                    got.header_start !== want.header_start ||
                    got.header_end !== want.header_end ||
                    got.parse_error !== want.parse_error ||
                    got.block_done !== want.block_done || got.block_ok !== want.block_ok) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: mismatch\n  exp %s\n  got %s", $realtime,
                                 fmt_res(want), fmt_res(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ohp_in_if  hdr_if ();
    ohp_out_if res_if ();

    obex_header_stream_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hdr   (hdr_if),
        .o_res   (res_if)
    );

    ohp_byte_scoreboard sb;
    t_in_item           stim_q[$];
    logic [BYTE_W-1:0]  blk_q[$];

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus building
    function automatic void push_byte(logic [BYTE_W-1:0] d, logic first,
                                      logic [LEN_W-1:0] total);
        t_in_item it;
        it.data_byte    = d;
        it.block_first  = first;
        it.total_length = total;
        stim_q.push_back(it);
    endfunction

    // flush the staged block; total_length is random noise off the first byte
    function automatic void emit_block(logic [LEN_W-1:0] total);
        foreach (blk_q[i])
            push_byte(blk_q[i], i == 0, (i == 0) ? total : LEN_W'($urandom));
        blk_q.delete();
    endfunction

    function automatic void add_header(logic [1:0] htype, logic [LEN_W-1:0] len_value,
                                       int unsigned var_n);
        int unsigned n;
        n = var_n;
        blk_q.push_back({htype, 6'($urandom)});
        if (htype <= HI_TYPE_VAR_LO) begin
            blk_q.push_back(len_value[15:8]);
            blk_q.push_back(len_value[7:0]);
        end else begin
            n = 32'((htype == HI_TYPE_ONE) ? CONTENT_ONE : CONTENT_FOUR);
        end
        repeat (n) blk_q.push_back(BYTE_W'($urandom));
    endfunction

    // one block: mostly well formed, sometimes cut, overrun, padded, short-length or pure noise
    function automatic void add_random_block();
        int unsigned      n_hdr;
        int unsigned      n;
        int unsigned      mode;
        logic [1:0]       ht;
        logic [LEN_W-1:0] total;
        n_hdr = $urandom_range(1, 4);
        for (int h = 0; h < n_hdr; h++) begin
            ht = 2'($urandom);
            n  = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 400) : $urandom_range(0, 8);
            add_header(ht, LEN_W'(n + 3), n);
        end
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                // length below the overhead
                add_header(2'($urandom_range(HT_VAR_HI, HI_TYPE_VAR_LO)),
                           LEN_W'($urandom_range(0, 2)), 0);
                repeat ($urandom_range(0, 3)) blk_q.push_back(BYTE_W'($urandom));
                total = LEN_W'(blk_q.size());
            end
            1: total = LEN_W'($urandom_range(1, blk_q.size()));
            2: begin
                // content runs past the block
                add_header(2'($urandom_range(HT_VAR_HI, HI_TYPE_VAR_LO)),
                           LEN_W'($urandom_range(12, 65535)), $urandom_range(0, 8));
                total = LEN_W'(blk_q.size());
            end
            3: total = LEN_W'(blk_q.size() + $urandom_range(1, 6));
            4: begin
                blk_q.delete();
                repeat ($urandom_range(1, 12)) blk_q.push_back(BYTE_W'($urandom));
                total = LEN_W'($urandom_range(0, 65535));
            end
            default: total = LEN_W'(blk_q.size());
        endcase
        emit_block(total);
        // stray bytes between blocks
        if (mode == 5) begin
            repeat ($urandom_range(1, 3))
                push_byte(BYTE_W'($urandom), 1'b0, LEN_W'($urandom));
            if ($urandom_range(0, 1) == 0)
                push_byte(BYTE_W'($urandom), 1'b1, '0);
        end
    endfunction

    function automatic void build_directed();
        push_byte(8'hFF, 1'b0, 16'hFFFF);        // no block open
        push_byte(8'h00, 1'b1, 16'h0000);        // empty block
        blk_q = '{8'h80};                        // one-byte header overruns
        emit_block(16'd1);
        blk_q = '{8'hBF, 8'hFF};
        emit_block(16'd2);
        blk_q = '{8'hC0, 8'h00, 8'hFF, 8'h00, 8'hFF};
        emit_block(16'd5);
        blk_q = '{8'h01, 8'h00, 8'h03};          // header with no content
        emit_block(16'd3);
        blk_q = '{8'h7F, 8'h00};                 // length field cut off
        emit_block(16'd2);
        blk_q = '{8'h40, 8'h00, 8'h02};          // length below overhead
        emit_block(16'd3);
        blk_q = '{8'h3F, 8'hFF, 8'hFF, 8'h00};   // content overruns the block
        emit_block(16'd4);
        blk_q = '{8'hFF, 8'h12};                 // dropped by the next block
        emit_block(16'hFFFF);
    endfunction

    // sender: bursts of random length, random gaps, two drain pauses
    task automatic drive_stimulus(int unsigned drain_a, int unsigned drain_b);
        int unsigned idx;
        int unsigned burst_len;
        int unsigned gap_len;
        int unsigned pick;
        idx = 0;
        while (idx < stim_q.size()) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                burst_len = $urandom_range(1, 4);
            else if (pick < 7)
                burst_len = $urandom_range(5, 30);
            else
                burst_len = $urandom_range(50, 200);
            gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < burst_len && idx < stim_q.size(); k++) begin
                if (idx == drain_a || idx == drain_b) begin
                    hdr_if.valid = 1'b0;
                    while (sb.pending() != 0) @(negedge clk);
                end
                hdr_if.valid        = 1'b1;
                hdr_if.data_byte    = stim_q[idx].data_byte;
                hdr_if.block_first  = stim_q[idx].block_first;
                hdr_if.total_length = stim_q[idx].total_length;
                do @(posedge clk); while (!hdr_if.ready);
                sb.note_input(stim_q[idx]);
                idx++;
                @(negedge clk);
            end
            hdr_if.valid = 1'b0;
            repeat (gap_len) @(negedge clk);
        end
    endtask

    // receiver: stall pattern of its own plus one long hold-off
    initial begin : rx_ctrl
        int unsigned       rx_mode;
        int unsigned       rx_left;
        logic [15:0]       rx_pattern;
        bit                held;
        res_if.ready = 1'b0;
        rx_left      = 0;
        rx_mode      = 0;
        rx_pattern   = '0;
        held         = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && sb != null && sb.inputs_seen >= HOLD_AFTER) begin
                res_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                held = 1'b1;
            end
            if (rx_left == 0) begin
                rx_mode    = $urandom_range(0, 3);
                rx_left    = $urandom_range(20, 200);
                rx_pattern = 16'($urandom);
            end
            rx_left--;
            case (rx_mode)
                0: res_if.ready = 1'b1;
                1: begin
                    res_if.ready = rx_pattern[0];
                    rx_pattern   = {rx_pattern[0], rx_pattern[15:1]};
                end
                2: res_if.ready = ($urandom_range(0, 3) != 0);
                default: res_if.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge clk) begin : res_mon
        t_res_item got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.header_id      = res_if.header_id;
            got.byte_kind      = res_if.byte_kind;
            got.content_byte   = res_if.content_byte;
            got.content_length = res_if.content_length;
            got.header_start   = res_if.header_start;
            got.header_end     = res_if.header_end;
            got.parse_error    = res_if.parse_error;
            got.block_done     = res_if.block_done;
            got.block_ok       = res_if.block_ok;
            sb.check_result(got);
        end
    end

    // main sequence
    initial begin : main_seq
        int unsigned directed_n;
        hdr_if.valid        = 1'b0;
        hdr_if.data_byte    = '0;
        hdr_if.block_first  = 1'b0;
        hdr_if.total_length = '0;
        rst_n               = 1'b0;
        sb                  = new();

        build_directed();
        directed_n = stim_q.size();
        while (stim_q.size() < directed_n + RANDOM_BYTES)
            add_random_block();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drive_stimulus(directed_n, stim_q.size() / 2);

        while (sb.pending() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
